// ----- src/tkbd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkbd_pkg
// Shared widths, register codes and state types for the touch key baseline
// detector.
// ----------------------------------------------------------------------------
package tkbd_pkg;

    // Key count and field widths
    localparam int NUM_KEYS   = 4;
    localparam int KEY_W      = 2;
    localparam int SAMPLE_W   = 16;
    localparam int FRAC_W     = 8;
    localparam int BASE_W     = SAMPLE_W + FRAC_W;
    localparam int WEIGHT_W   = 9;
    localparam int THR_W      = 16;
    localparam int CODE_W     = 8;
    localparam int SETUP_W    = THR_W + CODE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = SETUP_W;

    // Q8 weight constants
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 9'd256;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd26;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EMA_WEIGHT = 3'd0,
        REG_KEY0_SETUP = 3'd1,
        REG_KEY1_SETUP = 3'd2,
        REG_KEY2_SETUP = 3'd3,
        REG_KEY3_SETUP = 3'd4
    } cfg_reg_t;

    // Per-key stored state
    typedef struct packed {
        logic [BASE_W-1:0]   baseline;
        logic [SAMPLE_W-1:0] last_sample;
    } key_state_t;

    // Write-back request into the state memory
    typedef struct packed {
        logic             we;
        logic [KEY_W-1:0] waddr;
        key_state_t       wdata;
    } state_wr_t;

endpackage

// ----- src/tkbd_meas_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkbd_meas_if
// Sample channel: one sensor reading for one key per word.
// ----------------------------------------------------------------------------
interface tkbd_meas_if import tkbd_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [KEY_W-1:0]    key_index;
    logic [SAMPLE_W-1:0] sample;
    logic                read_ok;

    modport source (output valid, output key_index, output sample, output read_ok,
                    input ready);
    modport sink   (input valid, input key_index, input sample, input read_ok,
                    output ready);

endinterface

// ----- src/tkbd_evt_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkbd_evt_if
// Event channel: one key state change per word.
// ----------------------------------------------------------------------------
interface tkbd_evt_if import tkbd_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [KEY_W-1:0]  event_key;
    logic [CODE_W-1:0] key_code;
    logic              is_raw;
    logic              pressed;

    modport source (output valid, output event_key, output key_code, output is_raw,
                    output pressed, input ready);
    modport sink   (input valid, input event_key, input key_code, input is_raw,
                    input pressed, output ready);

endinterface

// ----- src/tkbd_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkbd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tkbd_cfg_if import tkbd_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

// ----- src/touch_key_baseline_detector.sv -----
`timescale 1ns / 1ps
// Each sample word passes stages 1 to 3, then the event output register.
// Throughput: one sample word per cycle, but output stalls hold the whole
// pipeline; sample ready follows event space. The per-key state memory is
// read at acceptance and written back from stage 2, with forwarding between.
// Reset sets the weight to 26 and clears setups and key states; baselines and
// last samples read zero through entry valid bits; no clearing pass needed.
// ----------------------------------------------------------------------------
// touch_key_baseline_detector
// Per-key EMA baseline tracking and press / release event detection.
// ----------------------------------------------------------------------------
module touch_key_baseline_detector import tkbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tkbd_meas_if.sink   meas,
    tkbd_evt_if.source  evt,
    tkbd_cfg_if.sink    cfg
);

    localparam int            PROD_A_W = BASE_W + WEIGHT_W;
    localparam int            PROD_B_W = SAMPLE_W + WEIGHT_W;
    localparam int            SUM_W    = PROD_A_W + 1;
    localparam logic [KEY_W:0] KEY_CNT = (KEY_W + 1)'(NUM_KEYS);

    // Configuration registers
    logic [WEIGHT_W-1:0] weight_reg;
    logic [SETUP_W-1:0]  setup_reg [NUM_KEYS];

    // Pipeline control
    logic en;

    // Stage 1: state read returns
    logic                s1_valid_reg;
    logic [KEY_W-1:0]    s1_key_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic                s1_ok_reg;
    key_state_t          mem_rd;
    key_state_t          s1_cur;
    logic [WEIGHT_W-1:0] w_inv;
    logic [PROD_A_W-1:0] prod_a_next;
    logic [PROD_B_W-1:0] prod_b_next;

    // Stage 2: blend and write back
    logic                s2_valid_reg;
    logic [KEY_W-1:0]    s2_key_reg;
    logic [SAMPLE_W-1:0] s2_sample_reg;
    logic                s2_ok_reg;
    logic                s2_zero_reg;
    key_state_t          s2_old_reg;
    logic [PROD_A_W-1:0] s2_prod_a_reg;
    logic [PROD_B_W-1:0] s2_prod_b_reg;
    logic [SUM_W-1:0]    blend_sum;
    key_state_t          s2_new;
    state_wr_t           wr;

    // Stage 3: down test
    logic                s3_valid_reg;
    logic [KEY_W-1:0]    s3_key_reg;
    key_state_t          s3_state_reg;
    logic [SETUP_W-1:0]  s3_setup;
    logic [THR_W:0]      s3_limit;
    logic                now_down;
    logic                change;
    logic [NUM_KEYS-1:0] key_down_reg;

    // Event output register
    logic              evt_valid_reg;
    logic [KEY_W-1:0]  evt_key_reg;
    logic [CODE_W-1:0] evt_code_reg;
    logic              evt_raw_reg;
    logic              evt_pressed_reg;

    // Whole pipeline advances unless a held event word blocks it
    assign en         = !(evt_valid_reg && !evt.ready);
    assign meas.ready = en;
    assign cfg.ready  = 1'b1;

    // Configuration writes; the weight is stored already saturated to 1.0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= WEIGHT_RESET;
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                setup_reg[i] <= '0;
            end
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_EMA_WEIGHT)
            begin
                weight_reg <= (cfg.data[WEIGHT_W-1:0] > WEIGHT_ONE) ?
                              WEIGHT_ONE : cfg.data[WEIGHT_W-1:0];
            end
            else if ((cfg.index >= REG_KEY0_SETUP) &&
                     ({1'b0, cfg.index} < ((CFG_IDX_W + 1)'(REG_KEY0_SETUP) +
                                           (CFG_IDX_W + 1)'(NUM_KEYS))))
            begin
                setup_reg[KEY_W'(cfg.index - REG_KEY0_SETUP)] <= cfg.data;
            end
        end
    end

    // State memory
    tkbd_state_mem u_state_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .rd_key  (meas.key_index),
        .wr      (wr),
        .rd_data (mem_rd)
    );

    // Stage 1 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= meas.valid && ({1'b0, meas.key_index} < KEY_CNT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_key_reg    <= meas.key_index;
            s1_sample_reg <= meas.sample;
            s1_ok_reg     <= meas.read_ok;
        end
    end

    // Forward the state being written back by the item one stage ahead
    always_comb
    begin
        if (s2_valid_reg && (s2_key_reg == s1_key_reg))
        begin
            s1_cur = s2_new;
        end
        else
        begin
            s1_cur = mem_rd;
        end
    end

    // Weighted products for the moving average
    assign w_inv       = WEIGHT_ONE - weight_reg;
    assign prod_a_next = PROD_A_W'(s1_cur.baseline) * PROD_A_W'(w_inv);
    assign prod_b_next = PROD_B_W'(s1_sample_reg) * PROD_B_W'(weight_reg);

    // Stage 2 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_key_reg    <= s1_key_reg;
            s2_sample_reg <= s1_sample_reg;
            s2_ok_reg     <= s1_ok_reg;
            s2_zero_reg   <= (s1_cur.baseline == '0);
            s2_old_reg    <= s1_cur;
            s2_prod_a_reg <= prod_a_next;
            s2_prod_b_reg <= prod_b_next;
        end
    end

    // New state: load on zero baseline, blend otherwise, keep on failed read
    assign blend_sum = SUM_W'(s2_prod_a_reg) + SUM_W'({s2_prod_b_reg, {FRAC_W{1'b0}}});

    always_comb
    begin
        if (!s2_ok_reg)
        begin
            s2_new = s2_old_reg;
        end
        else
        begin
            s2_new.last_sample = s2_sample_reg;
            if (s2_zero_reg)
            begin
                s2_new.baseline = {s2_sample_reg, {FRAC_W{1'b0}}};
            end
            else
            begin
                s2_new.baseline = blend_sum[FRAC_W +: BASE_W];
            end
        end
    end

    assign wr.we    = s2_valid_reg && en;
    assign wr.waddr = s2_key_reg;
    assign wr.wdata = s2_new;

    // Stage 3 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_key_reg   <= s2_key_reg;
            s3_state_reg <= s2_new;
        end
    end

    // Down test: last*256 > base + thr*256 reduces to last > base[23:8] + thr
    assign s3_setup = setup_reg[s3_key_reg];
    assign s3_limit = {1'b0, s3_state_reg.baseline[BASE_W-1:FRAC_W]} +
                      {1'b0, s3_setup[THR_W-1:0]};
    assign now_down = {1'b0, s3_state_reg.last_sample} > s3_limit;
    assign change   = s3_valid_reg && (now_down != key_down_reg[s3_key_reg]);

    // Key states and event output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_down_reg  <= '0;
            evt_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            evt_valid_reg <= change;
            if (change)
            begin
                key_down_reg[s3_key_reg] <= now_down;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && change)
        begin
            evt_key_reg     <= s3_key_reg;
            evt_code_reg    <= s3_setup[SETUP_W-1:THR_W];
            evt_raw_reg     <= (s3_setup[SETUP_W-1:THR_W] == '0);
            evt_pressed_reg <= now_down;
        end
    end

    assign evt.valid     = evt_valid_reg;
    assign evt.event_key = evt_key_reg;
    assign evt.key_code  = evt_code_reg;
    assign evt.is_raw    = evt_raw_reg;
    assign evt.pressed   = evt_pressed_reg;

endmodule

// ----- src/tkbd_state_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkbd_state_mem
// Per-key baseline and last sample store. Registered synchronous read,
// write-to-read bypass, and per-entry valid bits so that an entry
// never written reads as zero after reset.
// ----------------------------------------------------------------------------
module tkbd_state_mem import tkbd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [KEY_W-1:0] rd_key,
    input  state_wr_t        wr,
    output key_state_t       rd_data
);

    key_state_t          mem [NUM_KEYS];
    logic [NUM_KEYS-1:0] valid_reg;
    key_state_t          rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.waddr] <= wr.wdata;
        end
    end

    // Entry valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.we)
        begin
            valid_reg[wr.waddr] <= 1'b1;
        end
    end

    // Registered read; a same-edge write to the same key is passed through
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (wr.we && (wr.waddr == rd_key))
            begin
                rd_data_reg <= wr.wdata;
            end
            else if (valid_reg[rd_key])
            begin
                rd_data_reg <= mem[rd_key];
            end
            else
            begin
                rd_data_reg <= '0;
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/tkbd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkbd_checker
// Port-level checks on the touch key baseline detector, bound to the top.
// ----------------------------------------------------------------------------
module tkbd_checker import tkbd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              meas_valid,
    input logic              meas_ready,
    input logic              evt_valid,
    input logic              evt_ready,
    input logic [KEY_W-1:0]  evt_key,
    input logic [CODE_W-1:0] evt_code,
    input logic              evt_raw,
    input logic              evt_pressed
);

    // A stalled event word stays and holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_ready |=> evt_valid && $stable(evt_key) && $stable(evt_code) &&
                                    $stable(evt_raw) && $stable(evt_pressed))
    else $error("event word changed while stalled");

    // Samples are taken exactly when the event register has room
    assert property (@(posedge clk) disable iff (!rst_n)
        meas_ready == !(evt_valid && !evt_ready))
    else $error("sample ready does not follow event space");

    // A new event word with no stall in between comes from a matching accepted sample
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(evt_valid) && $past(meas_ready, 2) && $past(meas_ready, 3) &&
        $past(meas_ready, 4)
        |-> $past(meas_valid && meas_ready, 4))
    else $error("event word without a matching sample");

    // Raw flag marks a zero code
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid |-> (evt_raw == (evt_code == '0)))
    else $error("raw flag does not match event code");

endmodule

bind touch_key_baseline_detector tkbd_checker u_tkbd_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .meas_valid  (meas.valid),
    .meas_ready  (meas.ready),
    .evt_valid   (evt.valid),
    .evt_ready   (evt.ready),
    .evt_key     (evt.event_key),
    .evt_code    (evt.key_code),
    .evt_raw     (evt.is_raw),
    .evt_pressed (evt.pressed)
);
